### sv/pswl_pkg.sv
// ----------------------------------------------------------------------------
// pswl_pkg
// shared types and default sizes for the priority sorted wait list
// ----------------------------------------------------------------------------
package pswl_pkg;

   localparam int LIST_DEPTH_DEF    = 16;
   localparam int TASK_ID_BITS_DEF  = 8;
   localparam int PRIORITY_BITS_DEF = 8;

   // field widths on the stream ports
   localparam int OP_W    = 1;
   localparam int TASK_W  = 8;
   localparam int PRIO_W  = 8;
   localparam int COUNT_W = 5;

   // widest key any parameter value allows
   localparam int KEY_MAX_W = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // strobes broadcast to every cell of the row
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

### sv/pswl_cell.sv
// ----------------------------------------------------------------------------
// pswl_cell
// one slot of the sorted row: compares its entry with the request key and
// takes data from its left or right neighbor when the row shifts
// ----------------------------------------------------------------------------
module pswl_cell
   import pswl_pkg::*;
#(
   parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_cmd_type             cmd,
   input  logic [TASK_ID_BITS-1:0]  key_task,
   input  logic [PRIORITY_BITS-1:0] key_prio,
   // left neighbor (lower slot)
   input  logic                     prev_valid,
   input  logic                     prev_after,
   input  logic [TASK_ID_BITS-1:0]  prev_task,
   input  logic [PRIORITY_BITS-1:0] prev_prio,
   input  logic                     hit_in,
   // right neighbor (higher slot)
   input  logic                     next_valid,
   input  logic [TASK_ID_BITS-1:0]  next_task,
   input  logic [PRIORITY_BITS-1:0] next_prio,
   // own state toward both neighbors
   output logic                     valid,
   output logic                     after,
   output logic [TASK_ID_BITS-1:0]  slot_task,
   output logic [PRIORITY_BITS-1:0] slot_prio,
   output logic                     hit_out
);

   logic                     valid_ff, valid_in;
   logic [TASK_ID_BITS-1:0]  task_ff, task_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic                     match;

   assign after   = valid_ff && (prio_ff <= key_prio);
   assign match   = valid_ff && (task_ff == key_task);
   assign hit_out = hit_in || match;

   assign valid     = valid_ff;
   assign slot_task = task_ff;
   assign slot_prio = prio_ff;

   always_comb begin
      valid_in = valid_ff;
      task_in  = task_ff;
      prio_in  = prio_ff;
      if (cmd.insert) begin
         if (!after) begin
            valid_in = valid_ff || prev_valid;
            if (prev_after) begin
               task_in = key_task;
               prio_in = key_prio;
            end else begin
               task_in = prev_task;
               prio_in = prev_prio;
            end
         end
      end else if (cmd.remove) begin
         // first match and everything above it close the gap
         if (hit_out) begin
            valid_in = next_valid;
            task_in  = next_task;
            prio_in  = next_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      task_ff <= task_in;
      prio_ff <= prio_in;
   end

endmodule

### sv/priority_sorted_wait_list.sv
// ----------------------------------------------------------------------------
// priority_sorted_wait_list
// wait list of task ids held in ascending priority order in a row of cells
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  op, task_id, priority_req
//  rsp      out  rsp_tvalid/rsp_tready  found, overflow, entry_count, is_empty
//
//  one request per cycle: every cell compares its entry with the key at once
//  and the row shifts in the same edge; the result sits in an output register
//  a new request is taken while that register is empty or being drained
//  reset clears the cell valid bits, the count and the result valid bit
//  a stalled result holds the request side once the output register is full
// ----------------------------------------------------------------------------
module priority_sorted_wait_list
   import pswl_pkg::*;
#(
   parameter int LIST_DEPTH    = LIST_DEPTH_DEF,
   parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op[0], task_id[8:1], priority_req[16:9], zero[23:17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // found[0], overflow[1], entry_count[6:2], is_empty[7]
);

   localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);
   localparam int CNT_EXT  = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;

   logic                     accept;
   logic                     req_op;
   logic [KEY_MAX_W-1:0]     task_ext, prio_ext;
   logic [TASK_ID_BITS-1:0]  key_task;
   logic [PRIORITY_BITS-1:0] key_prio;
   logic                     full;
   logic                     found;
   logic                     overflow;
   cell_cmd_type             cmd;

   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [CNT_EXT-1:0]       count_ext;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;

   logic                     cell_valid [LIST_DEPTH];
   logic                     cell_after [LIST_DEPTH];
   logic [TASK_ID_BITS-1:0]  cell_task  [LIST_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio  [LIST_DEPTH];
   logic                     cell_hit   [LIST_DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign req_op   = req_tdata[0];
   assign task_ext = {{(KEY_MAX_W - TASK_W){1'b0}}, req_tdata[8:1]};
   assign prio_ext = {{(KEY_MAX_W - PRIO_W){1'b0}}, req_tdata[16:9]};
   assign key_task = task_ext[TASK_ID_BITS-1:0];
   assign key_prio = prio_ext[PRIORITY_BITS-1:0];

   assign full       = cell_valid[LIST_DEPTH-1];
   assign cmd.insert = accept && (req_op == OP_INSERT) && !full;
   assign cmd.remove = accept && (req_op == OP_REMOVE);
   assign found      = cmd.remove && cell_hit[LIST_DEPTH-1];
   assign overflow   = accept && (req_op == OP_INSERT) && full;

   generate
      for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
         logic                     p_valid, p_after, h_in, n_valid;
         logic [TASK_ID_BITS-1:0]  p_task, n_task;
         logic [PRIORITY_BITS-1:0] p_prio, n_prio;

         if (i == 0) begin : g_head
            // virtual head: everything sorts after it
            assign p_valid = 1'b1;
            assign p_after = 1'b1;
            assign p_task  = key_task;
            assign p_prio  = key_prio;
            assign h_in    = 1'b0;
         end else begin : g_mid
            assign p_valid = cell_valid[i-1];
            assign p_after = cell_after[i-1];
            assign p_task  = cell_task[i-1];
            assign p_prio  = cell_prio[i-1];
            assign h_in    = cell_hit[i-1];
         end

         if (i == LIST_DEPTH - 1) begin : g_tail
            assign n_valid = 1'b0;
            assign n_task  = cell_task[i];
            assign n_prio  = cell_prio[i];
         end else begin : g_body
            assign n_valid = cell_valid[i+1];
            assign n_task  = cell_task[i+1];
            assign n_prio  = cell_prio[i+1];
         end

         pswl_cell #(
            .TASK_ID_BITS  (TASK_ID_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .key_task   (key_task),
            .key_prio   (key_prio),
            .prev_valid (p_valid),
            .prev_after (p_after),
            .prev_task  (p_task),
            .prev_prio  (p_prio),
            .hit_in     (h_in),
            .next_valid (n_valid),
            .next_task  (n_task),
            .next_prio  (n_prio),
            .valid      (cell_valid[i]),
            .after      (cell_after[i]),
            .slot_task  (cell_task[i]),
            .slot_prio  (cell_prio[i]),
            .hit_out    (cell_hit[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (found) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   assign count_ext = CNT_EXT'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(count_in == '0), count_ext[COUNT_W-1:0], overflow, found};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
